@@ design/box_blur_3x3_rgb_top_assert.svh @@
// Assertion macros for the box blur block.
`ifndef BOX_BLUR_3X3_RGB_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/bbr_pkg.sv @@
// Shared types and constants of the box blur block.
`default_nettype none
package bbr_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int WID_W      = COL_W + 1;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = SUM_W + 1;
    localparam int RCP_SHIFT  = 18;
    localparam int RCP_W      = 18;
    localparam int PROD_W     = NUM_W + RCP_W;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]      count;
        logic                  row_end;
        logic                  frame_end;
    } t_job;

    typedef struct packed {
        logic push;
        logic full;
    } t_qctl;

    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

@@ design/bbr_front.sv @@
// Front end: raster counters, line store, 3x3 window and masked sums.
`default_nettype none
module bbr_front
    import bbr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [WID_W-1:0]  i_width,
    input  wire logic [ROW_W-1:0]  i_height,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_drain,
    input  wire logic [23:0]       i_pix,
    output t_job                   o_job,
    output t_qctl                  o_qctl,
    input  wire logic              i_full
);
    logic [47:0] r_mem [MAX_WIDTH];
    logic [47:0] r_rd, r_byp_d;
    logic        r_byp_v;
    logic [23:0] r_win [9];

    logic [COL_W-1:0] r_ci, r_oc, n_ci, n_oc;
    logic [ROW_W-1:0] r_ri, r_or, n_ri, n_or;

    logic             r_a_v, r_a_emit, r_a_re, r_a_fe;
    logic [23:0]      r_a_pix;
    logic [COL_W-1:0] r_a_idx;
    logic [1:0]       r_a_ucol, r_a_urow;
    logic [CNT_W-1:0] r_a_cnt;

    logic        acc, fire, emit, re, fe, ucol0, ucol2, urow0, urow2;
    logic [47:0] rd, wd;
    logic [23:0] nw [9];
    logic [1:0]  ncol, nrow;

    assign acc     = i_valid && o_ready;
    assign fire    = r_a_v && (!r_a_emit || !i_full);
    assign o_ready = !r_a_v || fire;

    assign emit  = (r_ri >= ROW_W'(2)) || (r_ri == ROW_W'(1) && r_ci != '0);
    assign re    = ({1'b0, r_oc} + WID_W'(1)) >= i_width;
    assign fe    = re && (({1'b0, r_or} + (ROW_W+1)'(1)) >= {1'b0, i_height});
    assign ucol0 = r_oc != '0;
    assign ucol2 = !re;
    assign urow0 = r_or != '0;
    assign urow2 = ({1'b0, r_or} + (ROW_W+1)'(1)) < {1'b0, i_height};
    assign ncol  = 2'd1 + {1'b0, ucol0} + {1'b0, ucol2};
    assign nrow  = 2'd1 + {1'b0, urow0} + {1'b0, urow2};

    always_comb begin
        n_ci = r_ci;
        n_ri = r_ri;
        n_oc = r_oc;
        n_or = r_or;
        if (({1'b0, r_ci} + WID_W'(1)) >= i_width) begin
            n_ci = '0;
            n_ri = r_ri + ROW_W'(1);
        end else begin
            n_ci = r_ci + COL_W'(1);
        end
        if (emit) begin
            if (fe) begin
                n_ci = '0;
                n_ri = '0;
                n_oc = '0;
                n_or = '0;
            end else if (re) begin
                n_oc = '0;
                n_or = r_or + ROW_W'(1);
            end else begin
                n_oc = r_oc + COL_W'(1);
            end
        end
    end

    assign rd = r_byp_v ? r_byp_d : r_rd;
    assign wd = {rd[23:0], r_a_pix};

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            nw[k] = r_win[k+3];
        end
        nw[6] = rd[47:24];
        nw[7] = rd[23:0];
        nw[8] = r_a_pix;
    end

    always_comb begin
        logic use_c, use_r;
        o_job.count     = r_a_cnt;
        o_job.row_end   = r_a_re;
        o_job.frame_end = r_a_fe;
        for (int ch = 0; ch < 3; ch++) begin
            o_job.sum[ch] = '0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    use_c = (c == 1) || (c == 0 && r_a_ucol[0]) || (c == 2 && r_a_ucol[1]);
                    use_r = (r == 1) || (r == 0 && r_a_urow[0]) || (r == 2 && r_a_urow[1]);
                    if (use_c && use_r) begin
                        o_job.sum[ch] = o_job.sum[ch]
                                      + SUM_W'(nw[c*3+r][ch*8 +: 8]);
                    end
                end
            end
        end
    end

    assign o_qctl.push     = fire && r_a_emit;
    assign o_qctl.full     = i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci    <= '0;
            r_ri    <= '0;
            r_oc    <= '0;
            r_or    <= '0;
            r_a_v   <= 1'b0;
            r_byp_v <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (acc) begin
                r_ci    <= n_ci;
                r_ri    <= n_ri;
                r_oc    <= n_oc;
                r_or    <= n_or;
                r_byp_v <= fire && (r_a_idx == r_ci);
            end
            if (acc) begin
                r_a_v <= 1'b1;
            end else if (fire) begin
                r_a_v <= 1'b0;
            end
            if (fire) begin
                for (int k = 0; k < 9; k++) begin
                    r_win[k] <= nw[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd     <= r_mem[r_ci];
            r_byp_d  <= wd;
            r_a_pix  <= i_drain ? 24'd0 : i_pix;
            r_a_idx  <= r_ci;
            r_a_emit <= emit;
            r_a_re   <= re;
            r_a_fe   <= fe;
            r_a_ucol <= {ucol2, ucol0};
            r_a_urow <= {urow2, urow0};
            r_a_cnt  <= CNT_W'(ncol) * CNT_W'(nrow);
        end
        if (fire) begin
            r_mem[r_a_idx] <= wd;
        end
    end
endmodule
`default_nettype wire

@@ design/bbr_queue.sv @@
// Short request queue between front and back end.
`default_nettype none
module bbr_queue
    import bbr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);
    t_job              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

@@ design/bbr_back.sv @@
// Back end: rounded division of the sums by the tap count, output register.
`default_nettype none
module bbr_back
    import bbr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [23:0] o_data,
    output logic      o_row_end,
    output logic      o_frame_end
);
    logic                   r_m_v, r_m_re, r_m_fe, r_o_v;
    logic [2:0][PROD_W-1:0] r_m_prod;
    logic                   o_adv, m_adv;
    logic [RCP_W-1:0]       m;

    assign o_adv   = !r_o_v || i_ready;
    assign m_adv   = !r_m_v || o_adv;
    assign o_pop   = i_valid && m_adv;
    assign o_valid = r_o_v;
    assign m       = recip(i_job.count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (m_adv) begin
                r_m_v <= i_valid;
            end
            if (o_adv) begin
                r_o_v <= r_m_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_m_prod[ch] <= PROD_W'({i_job.sum[ch], 1'b0} + NUM_W'(i_job.count))
                              * PROD_W'(m);
            end
            r_m_re <= i_job.row_end;
            r_m_fe <= i_job.frame_end;
        end
        if (o_adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                o_data[ch*8 +: 8] <= r_m_prod[ch][RCP_SHIFT +: 8];
            end
            o_row_end   <= r_m_re;
            o_frame_end <= r_m_fe;
        end
    end
endmodule
`default_nettype wire

@@ design/box_blur_3x3_rgb_top.sv @@
// Top level of the 3x3 edge-normalized RGB box blur.
// One pixel or drain request per clock is taken and one result per clock given,
// sustained while m_axis_tready is not held low; a result goes through the line
// store read, the window update with queue write, the multiply and the output
// register before it is offered. The result for a position comes with the request
// width+1 positions later, so width+1 drain requests must follow each frame.
// Channels are in tdata red at bits 7:0, green 15:8, blue 23:16.
`default_nettype none
module box_blur_3x3_rgb_top
    import bbr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
    input  wire logic        s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_red, out_green, out_blue
    output logic             m_axis_tuser,   // row_end
    output logic             m_axis_tlast    // frame_end
);
    logic [11:0]      r_fw;
    logic [12:0]      r_fh;
    logic [WID_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             wr, q_full, q_valid, q_pop;
    t_job             f_job, q_job;
    t_qctl            qctl;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {19'd0, r_fh} : {20'd0, r_fw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 12'd640;
            r_fh <= 13'd480;
        end else if (wr) begin
            if (paddr[2]) begin
                r_fh <= pwdata[12:0];
            end else begin
                r_fw <= pwdata[11:0];
            end
        end
    end

    always_comb begin
        priority if (r_fw == '0) begin
            eff_w = WID_W'(1);
        end else if (WID_W'(r_fw) > WID_W'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(r_fw);
        end
        priority if (r_fh == '0) begin
            eff_h = ROW_W'(1);
        end else if (ROW_W'(r_fh) > ROW_W'(MAX_HEIGHT)) begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_h = ROW_W'(r_fh);
        end
    end

    bbr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (eff_w),
        .i_height (eff_h),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_drain  (s_axis_tuser),
        .i_pix    (s_axis_tdata),
        .o_job    (f_job),
        .o_qctl   (qctl),
        .i_full   (q_full)
    );

    bbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (qctl.push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    bbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_row_end   (m_axis_tuser),
        .o_frame_end (m_axis_tlast)
    );

`include "box_blur_3x3_rgb_top_assert.svh"

    `BBR_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, qctl.push, !qctl.full)
    `BBR_ASSERT_IMP(a_pop_valid, i_clk, i_rst_n, q_pop, q_valid)
    `BBR_ASSERT_IMP(a_frame_row, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the 3x3 edge-normalized RGB box blur: directed and random frames against a predictor.
`default_nettype none
module tb;
    import bbr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } t_blur;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    box_blur_3x3_rgb_top DUT (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [47:0] lines [MAX_WIDTH];
    logic [23:0] win [9];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned cfg_w = 640, cfg_h = 480;
    t_blur       blur_q [$];
    int          errors = 0;
    int          idle_cnt = 0;
    bit          no_idle = 1'b0;
    int          hold_off = 0;
    bit          done = 1'b0;

    function automatic int unsigned eff(int unsigned v, int unsigned mx);
        if (v == 0) return 1;
        return (v > mx) ? mx : v;
    endfunction

    function automatic logic [7:0] avg(int unsigned s, int unsigned n);
        return 8'((2 * s + n) / (2 * n));
    endfunction

    task automatic predict_blur(logic kind, logic [23:0] rgb);
        int unsigned w, h, ci, ri, idx, sr, sg, sb, n;
        logic [23:0] pix, up1, up2, p;
        bit uc [3], ur [3];
        t_blur r;
        w = eff(cfg_w, MAX_WIDTH);
        h = eff(cfg_h, MAX_HEIGHT);
        ci = in_col; ri = in_row;
        pix = kind ? 24'd0 : {rgb[7:0], rgb[15:8], rgb[23:16]};
        idx = (ci < MAX_WIDTH) ? ci : MAX_WIDTH - 1;
        up2 = lines[idx][47:24];
        up1 = lines[idx][23:0];
        lines[idx] = {up1, pix};
        for (int k = 0; k < 6; k++) win[k] = win[k + 3];
        win[6] = up2; win[7] = up1; win[8] = pix;
        if (ci + 1 >= w) begin
            in_col = 0;
            in_row = (ri + 1) & 32'h1FFF;
        end else begin
            in_col = (ci + 1) & 32'h7FF;
        end
        if (!(ri >= 2 || (ri == 1 && ci >= 1))) return;
        r.row_end = (out_col + 1 >= w);
        r.frame_end = r.row_end && (out_row + 1 >= h);
        uc[0] = out_col > 0; uc[1] = 1; uc[2] = !r.row_end;
        ur[0] = out_row > 0; ur[1] = 1; ur[2] = out_row + 1 < h;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (int c = 0; c < 3; c++)
            for (int rr = 0; rr < 3; rr++)
                if (uc[c] && ur[rr]) begin
                    p = win[c * 3 + rr];
                    sr += p[23:16]; sg += p[15:8]; sb += p[7:0]; n++;
                end
        r.red = avg(sr, n); r.green = avg(sg, n); r.blue = avg(sb, n);
        blur_q.push_back(r);
        if (r.frame_end) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else if (r.row_end) begin
            out_col = 0;
            out_row = (out_row + 1) & 32'h1FFF;
        end else begin
            out_col = (out_col + 1) & 32'h7FF;
        end
    endtask

    task automatic send_pixel(logic kind, logic [23:0] rgb);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= rgb;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_blur(kind, rgb);
    endtask

    task automatic write_reg(logic [2:0] a, logic [31:0] d);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (a == ADDR_WIDTH) cfg_w = d & 32'hFFF;
        else cfg_h = d & 32'h1FFF;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        wait_drained();
        write_reg(ADDR_WIDTH, w);
        write_reg(ADDR_HEIGHT, h);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // one frame plus its drain; mode 0 random, 1 all max, 2 all zero
    task automatic send_frame(int mode);
        int unsigned w, h;
        logic [23:0] px;
        w = eff(cfg_w, MAX_WIDTH);
        h = eff(cfg_h, MAX_HEIGHT);
        for (int i = 0; i < w * h; i++) begin
            px = (mode == 1) ? 24'hFFFFFF : (mode == 2) ? 24'h0 : 24'($urandom);
            send_pixel(1'b0, px);
        end
        for (int i = 0; i <= w; i++) send_pixel(1'b1, 24'($urandom));
    endtask

    task automatic test_directed();
        set_size(1, 1);
        send_frame(1);
        set_size(3, 3);
        send_frame(1);
        send_frame(2);
        set_size(4, 2);
        send_frame(0);
    endtask

    task automatic test_clamp();
        set_size(0, 0);
        send_frame(0);
        set_size(1, 3);
        send_frame(0);
        set_size(5, 1);
        send_frame(0);
    endtask

    task automatic test_out_of_order();
        set_size(3, 2);
        send_pixel(1'b1, 24'hFFFFFF);
        for (int i = 0; i < 5; i++) send_pixel(1'b0, 24'($urandom));
        for (int i = 0; i < 4; i++) send_pixel(1'b0, 24'($urandom));
        send_frame(0);
    endtask

    task automatic test_backpressure();
        set_size(6, 4);
        hold_off = 200;
        send_frame(0);
        wait_drained();
        send_frame(0);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 600) begin
            set_size($urandom_range(1, 12), $urandom_range(1, 8));
            send_frame(0);
            sent += eff(cfg_w, MAX_WIDTH) * (eff(cfg_h, MAX_HEIGHT) + 1) + 1;
        end
        set_size(8191, 3);
        no_idle = 1'b1;
        set_size(5, 3);
        send_frame(0);
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (idle_cnt > 0) begin
            idle_cnt <= idle_cnt - 1;
            m_axis_tready <= (idle_cnt == 1);
        end else if ($urandom_range(0, 7) == 0) begin
            idle_cnt <= $urandom_range(1, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_blur exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (blur_q.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                exp_r = blur_q.pop_front();
                if (m_axis_tdata[7:0] !== exp_r.red) begin
                    $error("out_red exp %h got %h", exp_r.red, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[15:8] !== exp_r.green) begin
                    $error("out_green exp %h got %h", exp_r.green, m_axis_tdata[15:8]);
                    errors++;
                end
                if (m_axis_tdata[23:16] !== exp_r.blue) begin
                    $error("out_blue exp %h got %h", exp_r.blue, m_axis_tdata[23:16]);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.row_end) begin
                    $error("row_end exp %b got %b", exp_r.row_end, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== exp_r.frame_end) begin
                    $error("frame_end exp %b got %b", exp_r.frame_end, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no request, result or register access moving
    int stuck = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck > 20000 && !done) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) lines[i] = '0;
        for (int i = 0; i < 9; i++) win[i] = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_clamp();
        test_out_of_order();
        test_backpressure();
        test_random();
        wait_drained();
        done = 1'b1;
        if (errors == 0 && blur_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
